>>> rtl/irdl_pkg.sv
// ----------------------------------------------------------------------------
// IR distance linearizer package
// Shared widths, curve breakpoints and the constant distance tables that the
// linearizer core reads in its mapping stage.
// ----------------------------------------------------------------------------
package irdl_pkg;

   // Block size and converter resolution.
   localparam int unsigned SAMPLES  = 20;
   localparam int unsigned ADC_BITS = 10;

   // Field widths.
   localparam int unsigned SAMPLE_W  = 10;
   localparam int unsigned DIST_W    = 15;
   localparam int unsigned AVG_OUT_W = 10;
   localparam int unsigned SUM_W     = 16;
   localparam int unsigned CNT_W     = 6;

   // Average by reciprocal multiply: floor(sum / SAMPLES) = (sum * AVG_MULT) >> AVG_SHIFT.
   // The rounding error of AVG_MULT stays below SAMPLES, so the result is exact
   // for every sum below 2**SUM_W.
   localparam int unsigned AVG_SHIFT = SUM_W + 7;
   localparam int unsigned AVG_MULT  = ((2 ** AVG_SHIFT) + SAMPLES - 1) / SAMPLES;
   localparam int unsigned MULT_W    = $clog2(AVG_MULT + 1);
   localparam int unsigned PROD_W    = SUM_W + MULT_W;
   localparam int unsigned AVG_W     = $clog2(((2 ** SUM_W) - 1) / SAMPLES + 1);

   // Curve limits on the average.
   localparam int unsigned FRAC_BITS  = 8;
   localparam int unsigned LOW_LIMIT  = 80;
   localparam int unsigned HOLD_LIMIT = 490;
   localparam int unsigned NEAR_BASE  = 81;   // first average of the near table
   localparam int unsigned FAR_BASE   = 277;  // first average of the far table
   localparam int unsigned NEAR_TOP   = FAR_BASE - 1;
   localparam int unsigned NEAR_CM    = 80;

   // Segment data: lower and upper breakpoint, distance at the lower end in
   // whole cm, and the divisor scaled by DIV_SCALE.
   localparam int unsigned SEG_COUNT = 7;
   localparam int unsigned DIV_SCALE = 100;
   localparam int unsigned SEG_LO  [SEG_COUNT] = '{80, 87, 106, 124, 150, 196, 276};
   localparam int unsigned SEG_HI  [SEG_COUNT] = '{87, 106, 124, 150, 196, 276, 490};
   localparam int unsigned SEG_CM  [SEG_COUNT] = '{80, 70, 60, 50, 40, 30, 20};
   localparam int unsigned SEG_DIV [SEG_COUNT] = '{77, 211, 200, 288, 511, 888, 2377};
   localparam int unsigned SEG_STEP_CM = 10;

   // Distance tables.
   localparam int unsigned LUT_DEPTH = 256;
   localparam int unsigned LUT_AW    = $clog2(LUT_DEPTH);

   typedef logic [DIST_W-1:0] dist_lut_type [LUT_DEPTH];

   // Distance in Q7.8 cm for one average. Averages up to LOW_LIMIT give NEAR_CM,
   // those above HOLD_LIMIT give zero; the core never reads those entries.
   function automatic logic [DIST_W-1:0] dist_of(input int unsigned avg);
      int unsigned k;
      int unsigned d;
      int unsigned q;
      logic        found;
      logic [DIST_W-1:0] r;
      r     = '0;
      found = 1'b0;
      if (avg <= LOW_LIMIT) begin
         r = DIST_W'(NEAR_CM << FRAC_BITS);
      end else if (avg <= HOLD_LIMIT) begin
         for (k = 0; k < SEG_COUNT; k++) begin
            if (!found) begin
               if (avg == SEG_HI[k]) begin
                  r     = DIST_W'((SEG_CM[k] - SEG_STEP_CM) << FRAC_BITS);
                  found = 1'b1;
               end else if (avg > SEG_LO[k] && avg < SEG_HI[k]) begin
                  d     = avg - SEG_LO[k];
                  q     = (d * (DIV_SCALE << FRAC_BITS) + SEG_DIV[k] / 2) / SEG_DIV[k];
                  r     = DIST_W'((SEG_CM[k] << FRAC_BITS) - q);
                  found = 1'b1;
               end
            end
         end
      end
      return r;
   endfunction

   function automatic dist_lut_type build_lut(input int unsigned base);
      dist_lut_type lut;
      int unsigned  i;
      for (i = 0; i < LUT_DEPTH; i++) begin
         lut[i] = dist_of(base + i);
      end
      return lut;
   endfunction

   localparam dist_lut_type NEAR_LUT = build_lut(NEAR_BASE);
   localparam dist_lut_type FAR_LUT  = build_lut(FAR_BASE);

endpackage

>>> rtl/ir_distance_linearizer_core.sv
// ----------------------------------------------------------------------------
// IR distance linearizer core
// Averages blocks of converter readings and maps each average to a distance
// in Q7.8 cm through a seven-segment piecewise-linear curve.
// ----------------------------------------------------------------------------
// The result for a block passes through the block total register, the
// average register and the result register after its last item is accepted.
// Throughput: one item per cycle unless the block total stage stalls; each stage holds
// one block total, average or result and stalls only when the stage after it is full and stalled.
// Reset: synchronous, active high; clears the running sum, the item count,
// the stored last distance and every stage's valid flag.
module ir_distance_linearizer_core (
   input  logic        clock,
   input  logic        reset,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] adc_sample, [15:10] zero
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [14:0] distance_q8, [24:15] average_reading, [31:25] zero
   output logic        rsp_tuser    // [0] held_previous
);

   // ------------------------------------------------------------------------
   // Accumulator: running sum and item count of the current block.
   // ------------------------------------------------------------------------
   logic [irdl_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [irdl_pkg::CNT_W-1:0] count_ff, count_in;
   logic [irdl_pkg::SUM_W-1:0] sum_next;
   logic                       block_end;
   logic                       req_acc;

   // Block total stage.
   logic                       tot_vld_ff, tot_vld_in;
   logic [irdl_pkg::SUM_W-1:0] tot_ff;
   logic                       tot_rdy;

   // Average stage.
   logic                        av_vld_ff, av_vld_in;
   logic [irdl_pkg::AVG_W-1:0]  avg_ff;
   logic [irdl_pkg::AVG_W-1:0]  avg_in;
   logic [irdl_pkg::PROD_W-1:0] avg_prod;
   logic                        av_rdy;

   // Result stage.
   logic                         rsp_vld_ff, rsp_vld_in;
   logic [irdl_pkg::DIST_W-1:0]  rsp_dist_ff, dist_in;
   logic [irdl_pkg::AVG_OUT_W-1:0] rsp_avg_ff;
   logic                         rsp_held_ff, held_in;
   logic                         rsp_rdy;
   logic                         rsp_load;
   logic [irdl_pkg::DIST_W-1:0]  last_dist_ff, last_dist_in;
   logic [irdl_pkg::LUT_AW-1:0]  near_idx;
   logic [irdl_pkg::LUT_AW-1:0]  far_idx;

   // Pipeline flow: each stage moves when the next one is empty or moving.
   assign rsp_rdy    = !rsp_vld_ff || rsp_tready;
   assign rsp_load   = rsp_rdy && av_vld_ff;
   assign av_rdy     = !av_vld_ff || rsp_rdy;
   assign tot_rdy    = !tot_vld_ff || av_rdy;
   assign req_tready = tot_rdy;
   assign req_acc    = req_tvalid && tot_rdy;

   // Only the low ADC_BITS bits of a reading count.
   assign sum_next  = sum_ff + irdl_pkg::SUM_W'(req_tdata[irdl_pkg::ADC_BITS-1:0]);
   assign block_end = ((irdl_pkg::CNT_W+1)'(count_ff) + (irdl_pkg::CNT_W+1)'(1))
                      >= (irdl_pkg::CNT_W+1)'(irdl_pkg::SAMPLES);

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (req_acc) begin
         if (block_end) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_next;
            count_in = count_ff + irdl_pkg::CNT_W'(1);
         end
      end
   end

   assign tot_vld_in = tot_rdy ? (req_acc && block_end) : tot_vld_ff;

   // Truncated average by reciprocal multiply.
   assign avg_prod  = irdl_pkg::PROD_W'(tot_ff) * irdl_pkg::PROD_W'(irdl_pkg::AVG_MULT);
   assign avg_in    = avg_prod[irdl_pkg::AVG_SHIFT +: irdl_pkg::AVG_W];
   assign av_vld_in = av_rdy ? tot_vld_ff : av_vld_ff;

   // ------------------------------------------------------------------------
   // Curve mapping. Averages up to 80 give 80 cm, those from 81 to 276 read the
   // near table, those from 277 to 490 the far table. Above 490 the previous distance is repeated.
   // ------------------------------------------------------------------------
   assign near_idx = irdl_pkg::LUT_AW'(avg_ff - irdl_pkg::AVG_W'(irdl_pkg::NEAR_BASE));
   assign far_idx  = irdl_pkg::LUT_AW'(avg_ff - irdl_pkg::AVG_W'(irdl_pkg::FAR_BASE));

   always_comb begin
      held_in = 1'b0;
      priority if (avg_ff <= irdl_pkg::AVG_W'(irdl_pkg::LOW_LIMIT)) begin
         dist_in = irdl_pkg::DIST_W'(irdl_pkg::NEAR_CM << irdl_pkg::FRAC_BITS);
      end else if (avg_ff > irdl_pkg::AVG_W'(irdl_pkg::HOLD_LIMIT)) begin
         dist_in = last_dist_ff;
         held_in = 1'b1;
      end else if (avg_ff <= irdl_pkg::AVG_W'(irdl_pkg::NEAR_TOP)) begin
         dist_in = irdl_pkg::NEAR_LUT[near_idx];
      end else begin
         dist_in = irdl_pkg::FAR_LUT[far_idx];
      end
   end

   assign rsp_vld_in   = rsp_rdy ? av_vld_ff : rsp_vld_ff;
   assign last_dist_in = rsp_load ? dist_in : last_dist_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         tot_vld_ff   <= 1'b0;
         av_vld_ff    <= 1'b0;
         rsp_vld_ff   <= 1'b0;
         last_dist_ff <= '0;
      end else begin
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         tot_vld_ff   <= tot_vld_in;
         av_vld_ff    <= av_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
         last_dist_ff <= last_dist_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_acc && block_end) begin
         tot_ff <= sum_next;
      end
      if (av_rdy && tot_vld_ff) begin
         avg_ff <= avg_in;
      end
      if (rsp_load) begin
         rsp_dist_ff <= dist_in;
         rsp_avg_ff  <= avg_ff[irdl_pkg::AVG_OUT_W-1:0];
         rsp_held_ff <= held_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {7'd0, rsp_avg_ff, rsp_dist_ff};
   assign rsp_tuser  = rsp_held_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   // The item count never reaches the block size.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (irdl_pkg::CNT_W+1)'(count_ff) < (irdl_pkg::CNT_W+1)'(irdl_pkg::SAMPLES))
      else $error("item count reached the block size");

   // A held result repeats the distance stored before it.
   a_hold_repeats: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && held_in) |=> (rsp_dist_ff == $past(last_dist_ff)))
      else $error("held result does not repeat the previous distance");

   // A block total that cannot move on is kept, not dropped.
   a_total_kept: assert property (@(posedge clock) disable iff (reset)
      (tot_vld_ff && !av_rdy) |=> (tot_vld_ff && $stable(tot_ff)))
      else $error("stalled block total was lost");

endmodule
